[hdl/fgn_pkg.sv]
`default_nettype none
package fgn_pkg;

  typedef logic [3:0] opcode_t;

  localparam opcode_t OP_PERM   = 4'd0;
  localparam opcode_t OP_G1     = 4'd1;
  localparam opcode_t OP_G2X    = 4'd2;
  localparam opcode_t OP_G2Y    = 4'd3;
  localparam opcode_t OP_G3X    = 4'd4;
  localparam opcode_t OP_G3Y    = 4'd5;
  localparam opcode_t OP_G3Z    = 4'd6;
  localparam opcode_t OP_NOISE1 = 4'd7;
  localparam opcode_t OP_FBM2   = 4'd8;
  localparam opcode_t OP_FBM3   = 4'd9;

  typedef logic [1:0] cfg_index_t;

  localparam cfg_index_t CFG_OCTAVES = 2'd0;
  localparam cfg_index_t CFG_FREQ    = 2'd1;
  localparam cfg_index_t CFG_AMP     = 2'd2;

  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 25;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Three in Q16, the constant term of the s-curve.
  localparam logic [17:0] S_THREE = 18'd196608;

endpackage
`default_nettype wire

[hdl/fgn_mul.sv]
`default_nettype none
module fgn_mul (
  input  wire                                   clk,
  input  wire logic signed [fgn_pkg::MUL_A_W-1:0] mul_a,
  input  wire logic signed [fgn_pkg::MUL_B_W-1:0] mul_b,
  output logic signed [fgn_pkg::MUL_P_W-1:0]    prod
);
  import fgn_pkg::*;

  logic signed [MUL_P_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
  end

  assign prod = prod_r;

endmodule
`default_nettype wire

[hdl/fractal_gradient_noise_core.sv]
// Fractal gradient noise core.
// Input channel (in_valid/in_stall): opcodes 0 to 6 write one entry of the
// permutation or gradient tables and produce no result; opcodes 7 to 9
// evaluate 1D noise or a 2D or 3D octave sum and produce one result
// transaction on the output channel (out_valid/out_stall). Other opcodes
// are dropped. A table write does not make the core busy; in_stall stays
// low. An evaluation holds in_stall high until its result has been loaded
// into the output register; all multiplications go through one shared
// 33 x 25 multiplier with a registered product, stepped by the sequencer.
// An octave sum first scales the coordinates by the frequency; each octave
// splits every axis, hashes the corners through the permutation table,
// takes gradient dot products, lerps them and adds the result scaled by
// the amplitude. With zero octaves the result is zero. The core takes its
// next transaction in the cycle the result appears, so evaluations do not
// overlap. The result register holds its value while out_stall is high,
// and an evaluation that finishes meanwhile waits for it to drain.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user
// must write it only while idle, which the core itself does not enforce.
// Reset clears the sequencer and output valid and restores the register
// defaults; the tables are not cleared and must be loaded before use.
`default_nettype none
module fractal_gradient_noise_core #(
  parameter int TABLE_SIZE  = 256,
  parameter int MAX_OCTAVES = 16
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_valid,
  output logic                      in_stall,
  input  wire fgn_pkg::opcode_t     in_opcode,
  input  wire logic [7:0]           in_table_index,
  input  wire logic signed [15:0]   in_table_value,
  input  wire logic signed [31:0]   in_coord_x,
  input  wire logic signed [31:0]   in_coord_y,
  input  wire logic signed [31:0]   in_coord_z,
  output logic                      out_valid,
  input  wire                       out_stall,
  output logic signed [31:0]        out_noise_value,
  input  wire                       cfg_we,
  input  wire fgn_pkg::cfg_index_t  cfg_index,
  input  wire logic [23:0]          cfg_data
);
  import fgn_pkg::*;

  localparam int TW = $clog2(TABLE_SIZE);
  localparam int CW = 16 + TW;
  localparam int OW = $clog2(MAX_OCTAVES + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SCALE, S_SPLIT, S_HASH, S_DOT, S_LERP, S_ACC, S_DONE
  } state_t;

  state_t state_r;

  logic [4:0]  oct_cfg_r;
  logic [23:0] freq_r;
  logic [23:0] ampc_r;

  logic [TW-1:0]        perm_mem [TABLE_SIZE];
  logic signed [15:0]   g1_mem   [TABLE_SIZE];
  logic signed [15:0]   g2x_mem  [TABLE_SIZE];
  logic signed [15:0]   g2y_mem  [TABLE_SIZE];
  logic signed [15:0]   g3x_mem  [TABLE_SIZE];
  logic signed [15:0]   g3y_mem  [TABLE_SIZE];
  logic signed [15:0]   g3z_mem  [TABLE_SIZE];

  logic [TW-1:0]        perm_rd_r;
  logic signed [15:0]   g1_rd_r, g2x_rd_r, g2y_rd_r, g3x_rd_r, g3y_rd_r, g3z_rd_r;

  logic [1:0]  dim_r;
  logic        fbm_r;
  logic [1:0]  ax_r;
  logic [1:0]  ph_r;
  logic [2:0]  hk_r;
  logic [2:0]  crn_r;
  logic [2:0]  dk_r;
  logic [1:0]  lv_r;

  logic [31:0]          pos_r  [0:2];
  logic [TW-1:0]        b0_r   [0:2];
  logic [15:0]          r0_r   [0:2];
  logic [16:0]          s_r    [0:2];
  logic [TW-1:0]        hi_r, hj_r;
  logic [TW-1:0]        h_r    [0:3];
  logic signed [34:0]   sum_r;
  logic signed [23:0]   val_r;
  logic signed [23:0]   pend_r [0:2];
  logic [23:0]          amp_r;
  logic signed [35:0]   acc_r;
  logic [OW-1:0]        oct_left_r;
  logic signed [31:0]   res_r;
  logic                 out_valid_r;
  logic signed [31:0]   out_val_r;

  logic                        in_acc;
  logic [TW-1:0]               tidx;
  logic [5:0]                  oct_lim;
  logic [TW-1:0]               b1x, b1y, b1z;
  logic [TW-1:0]               perm_addr;
  logic [TW-1:0]               hsel, gaddr;
  logic [1:0]                  comp;
  logic signed [16:0]          rsel;
  logic signed [15:0]          gsel;
  logic [17:0]                 fac;
  logic signed [24:0]          ldiff;
  logic signed [MUL_A_W-1:0]   mul_a;
  logic signed [MUL_B_W-1:0]   mul_b;
  logic signed [MUL_P_W-1:0]   prod;
  logic signed [34:0]          dsum;
  logic signed [23:0]          dot_v;
  logic signed [39:0]          lprod;
  logic signed [23:0]          lstep;
  logic signed [48:0]          aprod;
  logic signed [35:0]          acc_new;
  logic signed [31:0]          acc_sat;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_noise_value = out_val_r;

  assign tidx    = TW'(in_table_index);
  assign oct_lim = (6'(oct_cfg_r) > 6'(MAX_OCTAVES)) ? 6'(MAX_OCTAVES) : 6'(oct_cfg_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oct_cfg_r <= 5'd4;
      freq_r    <= 24'd65536;
      ampc_r    <= 24'd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OCTAVES: oct_cfg_r <= cfg_data[4:0];
        CFG_FREQ:    freq_r    <= cfg_data;
        CFG_AMP:     ampc_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign b1x = b0_r[0] + 1'b1;
  assign b1y = b0_r[1] + 1'b1;
  assign b1z = b0_r[2] + 1'b1;

  always_comb begin
    unique case (hk_r)
      3'd0:    perm_addr = b0_r[0];
      3'd1:    perm_addr = b1x;
      3'd2:    perm_addr = hi_r + b0_r[1];
      3'd3:    perm_addr = hj_r + b0_r[1];
      3'd4:    perm_addr = hi_r + b1y;
      3'd5:    perm_addr = hj_r + b1y;
      default: perm_addr = b0_r[0];
    endcase
  end

  assign hsel  = h_r[crn_r[1:0]];
  assign gaddr = (dim_r == 2'd3) ? hsel + (crn_r[2] ? b1z : b0_r[2]) : hsel;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      case (in_opcode)
        OP_PERM: perm_mem[tidx] <= in_table_value[TW-1:0];
        OP_G1:   g1_mem[tidx]   <= in_table_value;
        OP_G2X:  g2x_mem[tidx]  <= in_table_value;
        OP_G2Y:  g2y_mem[tidx]  <= in_table_value;
        OP_G3X:  g3x_mem[tidx]  <= in_table_value;
        OP_G3Y:  g3y_mem[tidx]  <= in_table_value;
        OP_G3Z:  g3z_mem[tidx]  <= in_table_value;
        default: ;
      endcase
    end
    perm_rd_r <= perm_mem[perm_addr];
    g1_rd_r   <= g1_mem[gaddr];
    g2x_rd_r  <= g2x_mem[gaddr];
    g2y_rd_r  <= g2y_mem[gaddr];
    g3x_rd_r  <= g3x_mem[gaddr];
    g3y_rd_r  <= g3y_mem[gaddr];
    g3z_rd_r  <= g3z_mem[gaddr];
  end

  assign comp = dk_r[1:0] - 2'd1;
  assign rsel = {crn_r[comp], r0_r[comp]};

  always_comb begin
    if (dim_r == 2'd1) begin
      gsel = g1_rd_r;
    end else if (dim_r == 2'd2) begin
      gsel = (comp == 2'd0) ? g2x_rd_r : g2y_rd_r;
    end else begin
      case (comp)
        2'd0:    gsel = g3x_rd_r;
        2'd1:    gsel = g3y_rd_r;
        default: gsel = g3z_rd_r;
      endcase
    end
  end

  assign fac   = S_THREE - {1'b0, r0_r[ax_r], 1'b0};
  assign ldiff = {val_r[23], val_r} - {pend_r[lv_r][23], pend_r[lv_r]};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_SCALE: begin
        mul_a = {pos_r[ax_r][31], pos_r[ax_r]};
        mul_b = {1'b0, freq_r};
      end
      S_SPLIT: begin
        if (ph_r == 2'd0) begin
          mul_a = {17'd0, pos_r[ax_r][15:0]};
          mul_b = {9'd0, pos_r[ax_r][15:0]};
        end else begin
          mul_a = {17'd0, prod[31:16]};
          mul_b = {7'd0, fac};
        end
      end
      S_DOT: begin
        mul_a = {{16{rsel[16]}}, rsel};
        mul_b = {{9{gsel[15]}}, gsel};
      end
      S_LERP: begin
        mul_a = {{8{ldiff[24]}}, ldiff};
        mul_b = {8'd0, s_r[lv_r]};
      end
      S_ACC: begin
        mul_a = {{9{val_r[23]}}, val_r};
        mul_b = {1'b0, amp_r};
      end
      default: ;
    endcase
  end

  fgn_mul u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .prod  (prod)
  );

  assign dsum    = sum_r + prod[34:0];
  assign dot_v   = 24'(dsum >>> 14);
  assign lprod   = prod[39:0];
  assign lstep   = 24'(lprod >>> 16);
  assign aprod   = prod[48:0];
  assign acc_new = acc_r + 36'(aprod >>> 16);
  always_comb begin
    if (acc_new > 36'sd2147483647) begin
      acc_sat = 32'sh7FFFFFFF;
    end else if (acc_new < -36'sd2147483648) begin
      acc_sat = 32'sh80000000;
    end else begin
      acc_sat = acc_new[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            ax_r <= 2'd0;
            ph_r <= 2'd0;
            pos_r[0] <= in_coord_x;
            pos_r[1] <= in_coord_y;
            pos_r[2] <= in_coord_z;
            amp_r <= ampc_r;
            acc_r <= '0;
            oct_left_r <= OW'(oct_lim);
            case (in_opcode) inside
              OP_NOISE1: begin
                dim_r   <= 2'd1;
                fbm_r   <= 1'b0;
                state_r <= S_SPLIT;
              end
              OP_FBM2, OP_FBM3: begin
                dim_r <= (in_opcode == OP_FBM3) ? 2'd3 : 2'd2;
                fbm_r <= 1'b1;
                if (oct_lim == 6'd0) begin
                  res_r   <= '0;
                  state_r <= S_DONE;
                end else begin
                  state_r <= S_SCALE;
                end
              end
              default: ;
            endcase
          end
        end
        S_SCALE: begin
          if (ph_r == 2'd0) begin
            ph_r <= 2'd1;
          end else begin
            pos_r[ax_r] <= 32'(prod[16 +: CW]);
            ph_r <= 2'd0;
            if (ax_r == dim_r - 2'd1) begin
              ax_r    <= 2'd0;
              state_r <= S_SPLIT;
            end else begin
              ax_r <= ax_r + 2'd1;
            end
          end
        end
        S_SPLIT: begin
          if (ph_r == 2'd0) begin
            b0_r[ax_r] <= pos_r[ax_r][16 +: TW];
            r0_r[ax_r] <= pos_r[ax_r][15:0];
            ph_r <= 2'd1;
          end else if (ph_r == 2'd1) begin
            ph_r <= 2'd2;
          end else begin
            s_r[ax_r] <= prod[16 +: 17];
            ph_r <= 2'd0;
            if (ax_r == dim_r - 2'd1) begin
              hk_r    <= 3'd0;
              state_r <= S_HASH;
            end else begin
              ax_r <= ax_r + 2'd1;
            end
          end
        end
        S_HASH: begin
          case (hk_r)
            3'd1: begin
              hi_r   <= perm_rd_r;
              h_r[0] <= perm_rd_r;
            end
            3'd2: begin
              hj_r   <= perm_rd_r;
              h_r[1] <= perm_rd_r;
            end
            3'd3: h_r[0] <= perm_rd_r;
            3'd4: h_r[1] <= perm_rd_r;
            3'd5: h_r[2] <= perm_rd_r;
            3'd6: h_r[3] <= perm_rd_r;
            default: ;
          endcase
          if ((dim_r == 2'd1 && hk_r == 3'd2) || hk_r == 3'd6) begin
            crn_r   <= 3'd0;
            dk_r    <= 3'd0;
            state_r <= S_DOT;
          end else begin
            hk_r <= hk_r + 3'd1;
          end
        end
        S_DOT: begin
          if (dk_r == 3'd0) begin
            dk_r <= 3'd1;
          end else if (dk_r <= {1'b0, dim_r}) begin
            sum_r <= (dk_r == 3'd1) ? '0 : dsum;
            dk_r  <= dk_r + 3'd1;
          end else begin
            val_r   <= dot_v;
            lv_r    <= 2'd0;
            ph_r    <= 2'd0;
            state_r <= S_LERP;
          end
        end
        S_LERP: begin
          if (lv_r == dim_r) begin
            ph_r    <= 2'd0;
            state_r <= S_ACC;
          end else if (!crn_r[lv_r]) begin
            pend_r[lv_r] <= val_r;
            crn_r   <= crn_r + 3'd1;
            dk_r    <= 3'd0;
            state_r <= S_DOT;
          end else if (ph_r == 2'd0) begin
            ph_r <= 2'd1;
          end else begin
            val_r <= pend_r[lv_r] + lstep;
            lv_r  <= lv_r + 2'd1;
            ph_r  <= 2'd0;
          end
        end
        S_ACC: begin
          if (!fbm_r) begin
            res_r   <= 32'(val_r);
            state_r <= S_DONE;
          end else if (ph_r == 2'd0) begin
            ph_r <= 2'd1;
          end else begin
            acc_r <= acc_new;
            amp_r <= amp_r >> 1;
            pos_r[0] <= {pos_r[0][30:0], 1'b0};
            pos_r[1] <= {pos_r[1][30:0], 1'b0};
            pos_r[2] <= {pos_r[2][30:0], 1'b0};
            ph_r <= 2'd0;
            ax_r <= 2'd0;
            if (oct_left_r == OW'(1)) begin
              res_r   <= acc_sat;
              state_r <= S_DONE;
            end else begin
              oct_left_r <= oct_left_r - OW'(1);
              state_r    <= S_SPLIT;
            end
          end
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_val_r   <= res_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[hdl/fgn_checker.sv]
`default_nettype none
module fgn_checker (
  input wire                      clk,
  input wire                      rst_n,
  input wire                      in_valid,
  input wire                      in_stall,
  input wire fgn_pkg::opcode_t    in_opcode,
  input wire                      out_valid,
  input wire                      out_stall,
  input wire logic signed [31:0]  out_noise_value
);
  import fgn_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_noise_value))
    else $error("stalled result changed");

  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall &&
    (in_opcode == OP_NOISE1 || in_opcode == OP_FBM2 || in_opcode == OP_FBM3)
    |=> in_stall)
    else $error("evaluation transaction did not occupy the core");

  a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_opcode <= OP_G3Z |=> !in_stall)
    else $error("table write left the core busy");

  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without an evaluation in progress");

endmodule

bind fractal_gradient_noise_core fgn_checker u_fgn_checker (.*);
`default_nettype wire

[tb/sv/fractal_gradient_noise_core_tb.sv]
`default_nettype none
module fractal_gradient_noise_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fgn_pkg::*;

  localparam int TSIZE = 256;
  localparam int MAXOCT = 16;
  localparam longint ONE = 65536;
  localparam int LIMIT_CYCLES = 6000000;
  localparam int RANDOM_ITEMS = 1350;

  logic clk;
  logic rst_n;
  logic in_valid;
  wire in_stall;
  opcode_t in_opcode;
  logic [7:0] in_table_index;
  logic signed [15:0] in_table_value;
  logic signed [31:0] in_coord_x, in_coord_y, in_coord_z;
  wire out_valid;
  logic out_stall;
  wire signed [31:0] out_noise_value;
  logic cfg_we;
  cfg_index_t cfg_index;
  logic [23:0] cfg_data;

  fractal_gradient_noise_core dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_opcode(in_opcode), .in_table_index(in_table_index),
    .in_table_value(in_table_value), .in_coord_x(in_coord_x),
    .in_coord_y(in_coord_y), .in_coord_z(in_coord_z), .out_valid(out_valid),
    .out_stall(out_stall), .out_noise_value(out_noise_value), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  typedef struct packed {
    opcode_t op;
    logic [7:0] idx;
    logic [15:0] val;
    logic [31:0] x, y, z;
  } noise_item_t;

  typedef struct {
    noise_item_t item;
    bit has_value;
    logic [31:0] value;
  } directed_row_t;

  logic [15:0] perm_mem [TSIZE];
  logic [15:0] grad1_mem [TSIZE];
  logic [15:0] grad2_mem [TSIZE][2];
  logic [15:0] grad3_mem [TSIZE][3];
  logic [4:0] octaves;
  logic [23:0] freq;
  logic [23:0] amp;

  logic [31:0] expected_noise [$];
  int errors;
  int cycle;
  bit idle_free;
  bit timed_out;

  function automatic longint fshr(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint wmod(longint v, longint m);
    longint r;
    r = v % m;
    if (r < 0) r += m;
    return r;
  endfunction

  function automatic int permv(int i);
    return perm_mem[i % TSIZE] % TSIZE;
  endfunction

  function automatic longint g16(logic [15:0] g);
    return longint'($signed(g));
  endfunction

  function automatic void axis(longint v, output int b0, output int b1,
                               output longint r0, output longint r1, output longint s);
    longint c;
    longint sq;
    c = fshr(v, 16);
    b0 = int'(wmod(c + 4096, TSIZE));
    b1 = (b0 + 1) % TSIZE;
    r0 = v - c * ONE;
    r1 = r0 - ONE;
    sq = fshr(r0 * r0, 16);
    s = fshr(sq * (3 * ONE - 2 * r0), 16);
  endfunction

  function automatic longint blend(longint s, longint a, longint b);
    return a + fshr(s * (b - a), 16);
  endfunction

  function automatic longint noise_line(longint x);
    int b0, b1;
    longint r0, r1, s, u, v;
    axis(x, b0, b1, r0, r1, s);
    u = fshr(r0 * g16(grad1_mem[permv(b0)]), 14);
    v = fshr(r1 * g16(grad1_mem[permv(b1)]), 14);
    return blend(s, u, v);
  endfunction

  function automatic longint dot_plane(int k, longint rx, longint ry);
    return fshr(rx * g16(grad2_mem[k][0]) + ry * g16(grad2_mem[k][1]), 14);
  endfunction

  function automatic longint dot_space(int k, longint rx, longint ry, longint rz);
    return fshr(rx * g16(grad3_mem[k][0]) + ry * g16(grad3_mem[k][1]) +
                rz * g16(grad3_mem[k][2]), 14);
  endfunction

  function automatic longint noise_lattice(bit three, longint x, longint y, longint z);
    int xb0, xb1, yb0, yb1, zb0, zb1, i, j, c00, c10, c01, c11;
    longint xr0, xr1, xs, yr0, yr1, ys, zr0, zr1, zs, a, b, c, d;
    axis(x, xb0, xb1, xr0, xr1, xs);
    axis(y, yb0, yb1, yr0, yr1, ys);
    axis(z, zb0, zb1, zr0, zr1, zs);
    i = permv(xb0);
    j = permv(xb1);
    c00 = permv((i + yb0) % TSIZE);
    c10 = permv((j + yb0) % TSIZE);
    c01 = permv((i + yb1) % TSIZE);
    c11 = permv((j + yb1) % TSIZE);
    if (!three) begin
      a = blend(xs, dot_plane(c00, xr0, yr0), dot_plane(c10, xr1, yr0));
      b = blend(xs, dot_plane(c01, xr0, yr1), dot_plane(c11, xr1, yr1));
      return blend(ys, a, b);
    end
    a = blend(xs, dot_space((c00 + zb0) % TSIZE, xr0, yr0, zr0),
              dot_space((c10 + zb0) % TSIZE, xr1, yr0, zr0));
    b = blend(xs, dot_space((c01 + zb0) % TSIZE, xr0, yr1, zr0),
              dot_space((c11 + zb0) % TSIZE, xr1, yr1, zr0));
    c = blend(ys, a, b);
    a = blend(xs, dot_space((c00 + zb1) % TSIZE, xr0, yr0, zr1),
              dot_space((c10 + zb1) % TSIZE, xr1, yr0, zr1));
    b = blend(xs, dot_space((c01 + zb1) % TSIZE, xr0, yr1, zr1),
              dot_space((c11 + zb1) % TSIZE, xr1, yr1, zr1));
    d = blend(ys, a, b);
    return blend(zs, c, d);
  endfunction

  function automatic longint fractal_sum(bit three, longint x, longint y, longint z);
    longint period, f, acc, a;
    int count;
    period = longint'(TSIZE) * ONE;
    f = longint'(freq);
    a = longint'(amp);
    acc = 0;
    count = (octaves > MAXOCT) ? MAXOCT : int'(octaves);
    x = wmod(fshr(x * f, 16), period);
    y = wmod(fshr(y * f, 16), period);
    z = wmod(fshr(z * f, 16), period);
    for (int k = 0; k < count; k++) begin
      acc += fshr(noise_lattice(three, x, y, z) * a, 16);
      x = (2 * x) % period;
      y = (2 * y) % period;
      z = (2 * z) % period;
      a = a >>> 1;
    end
    return acc;
  endfunction

  function automatic bit predict_noise(noise_item_t it, output logic [31:0] res);
    longint r;
    r = 0;
    case (it.op)
      OP_PERM: perm_mem[it.idx] = it.val;
      OP_G1: grad1_mem[it.idx] = it.val;
      OP_G2X: grad2_mem[it.idx][0] = it.val;
      OP_G2Y: grad2_mem[it.idx][1] = it.val;
      OP_G3X: grad3_mem[it.idx][0] = it.val;
      OP_G3Y: grad3_mem[it.idx][1] = it.val;
      OP_G3Z: grad3_mem[it.idx][2] = it.val;
      OP_NOISE1: r = noise_line(longint'($signed(it.x)));
      OP_FBM2: r = fractal_sum(0, $signed(it.x), $signed(it.y), $signed(it.z));
      OP_FBM3: r = fractal_sum(1, $signed(it.x), $signed(it.y), $signed(it.z));
      default: ;
    endcase
    if (it.op != OP_NOISE1 && it.op != OP_FBM2 && it.op != OP_FBM3) return 0;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    res = r[31:0];
    return 1;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle);
    errors++;
  endtask

  function automatic bit idle_roll();
    return !idle_free && ($urandom_range(99) < 11);
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > LIMIT_CYCLES && !timed_out) begin
      timed_out = 1;
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_noise.size() == 0) begin
        report_mismatch("unexpected transaction", out_noise_value, 'x);
      end else begin
        if (out_noise_value !== expected_noise[0])
          report_mismatch("noise_value", out_noise_value, expected_noise[0]);
        void'(expected_noise.pop_front());
      end
    end
  end

  always @(negedge clk) out_stall <= idle_roll();

  task automatic send_item(noise_item_t it);
    logic [31:0] res;
    cfg_we <= 0;
    while (idle_roll()) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_opcode <= it.op;
    in_table_index <= it.idx;
    in_table_value <= it.val;
    in_coord_x <= it.x;
    in_coord_y <= it.y;
    in_coord_z <= it.z;
    if (predict_noise(it, res)) expected_noise.push_back(res);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (expected_noise.size() != 0) @(negedge clk);
    repeat (3000) @(negedge clk);
  endtask

  task automatic write_reg(cfg_index_t i, logic [23:0] d);
    cfg_we <= 1;
    cfg_index <= i;
    cfg_data <= d;
    case (i)
      CFG_OCTAVES: octaves = d[4:0];
      CFG_FREQ: freq = d;
      default: amp = d;
    endcase
    @(negedge clk);
  endtask

  function automatic noise_item_t mk(opcode_t op, int idx, int val,
                                    logic [31:0] x, logic [31:0] y, logic [31:0] z);
    noise_item_t it;
    it.op = op;
    it.idx = idx[7:0];
    it.val = val[15:0];
    it.x = x;
    it.y = y;
    it.z = z;
    return it;
  endfunction

  function automatic noise_item_t random_item();
    noise_item_t it;
    int k;
    it.idx = 8'($urandom);
    it.x = $urandom;
    it.y = $urandom;
    it.z = $urandom;
    k = $urandom_range(99);
    if (k < 35) begin
      it.op = opcode_t'($urandom_range(OP_G3Z));
      it.val = 16'($urandom);
    end else if (k < 97) begin
      it.op = opcode_t'($urandom_range(OP_FBM3, OP_NOISE1));
      it.val = 16'($urandom);
      if ($urandom_range(3) == 0) begin
        it.x = $signed(it.x) >>> $urandom_range(24);
        it.y = $signed(it.y) >>> $urandom_range(24);
        it.z = $signed(it.z) >>> $urandom_range(24);
      end
    end else begin
      it.op = opcode_t'($urandom_range(15, 10));
      it.val = 16'($urandom);
    end
    return it;
  endfunction

  initial begin
    directed_row_t rows [$];
    directed_row_t row;
    int phase_items;
    errors = 0;
    cycle = 0;
    timed_out = 0;
    idle_free = 0;
    rst_n = 0;
    in_valid = 0;
    in_opcode = OP_PERM;
    in_table_index = 0;
    in_table_value = 0;
    in_coord_x = 0;
    in_coord_y = 0;
    in_coord_z = 0;
    out_stall = 0;
    cfg_we = 0;
    cfg_index = CFG_OCTAVES;
    cfg_data = 0;
    octaves = 4;
    freq = 24'd65536;
    amp = 24'd65536;
    repeat (8) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Fill every table so that no lookup reads an unwritten entry.
    for (int i = 0; i < TSIZE; i++) begin
      send_item(mk(OP_PERM, i, (i * 151 + 7) % TSIZE, 0, 0, 0));
      send_item(mk(OP_G1, i, $urandom, 0, 0, 0));
      send_item(mk(OP_G2X, i, $urandom, 0, 0, 0));
      send_item(mk(OP_G2Y, i, $urandom, 0, 0, 0));
      send_item(mk(OP_G3X, i, $urandom, 0, 0, 0));
      send_item(mk(OP_G3Y, i, $urandom, 0, 0, 0));
      send_item(mk(OP_G3Z, i, $urandom, 0, 0, 0));
    end

    // Integer points give zero noise since every fraction vanishes.
    row.has_value = 1;
    row.value = 0;
    row.item = mk(OP_NOISE1, 0, 0, 32'h0001_0000, 0, 0); rows.push_back(row);
    row.item = mk(OP_FBM2, 0, 0, 32'h0003_0000, 32'hFFFE_0000, 0); rows.push_back(row);
    row.item = mk(OP_FBM3, 0, 0, 0, 0, 0); rows.push_back(row);
    row.has_value = 0;
    row.item = mk(OP_PERM, 255, 16'hFFFF, 0, 0, 0); rows.push_back(row);
    row.item = mk(OP_G1, 0, 16'h8000, 0, 0, 0); rows.push_back(row);
    row.item = mk(OP_G1, 5, 16'h7FFF, 0, 0, 0); rows.push_back(row);
    row.item = mk(OP_G2X, 17, 16'h8000, 0, 0, 0); rows.push_back(row);
    row.item = mk(OP_G3Z, 99, 16'h7FFF, 0, 0, 0); rows.push_back(row);
    row.item = mk(OP_NOISE1, 0, 0, 32'h8000_0000, 0, 0); rows.push_back(row);
    row.item = mk(OP_NOISE1, 0, 0, 32'h7FFF_FFFF, 0, 0); rows.push_back(row);
    row.item = mk(OP_NOISE1, 0, 0, 32'hEFFF_8000, 0, 0); rows.push_back(row);
    row.item = mk(OP_FBM2, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0); rows.push_back(row);
    row.item = mk(OP_FBM3, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    rows.push_back(row);
    row.item = mk(OP_FBM3, 0, 0, 32'h0000_8000, 32'h0000_4000, 32'hFFFF_C000);
    rows.push_back(row);
    row.item = mk(4'd10, 3, 3, 1, 1, 1); rows.push_back(row);
    row.item = mk(4'd15, 3, 3, 1, 1, 1); rows.push_back(row);
    foreach (rows[i]) begin
      send_item(rows[i].item);
      if (rows[i].has_value) expected_noise[$] = rows[i].value;
    end
    drain();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin
          write_reg(CFG_OCTAVES, 0); write_reg(CFG_FREQ, 24'hFFFFFF);
          write_reg(CFG_AMP, 24'hFFFFFF);
        end
        1: begin
          write_reg(CFG_OCTAVES, 1); write_reg(CFG_FREQ, 0); write_reg(CFG_AMP, 0);
        end
        2: begin
          write_reg(CFG_OCTAVES, 31); write_reg(CFG_FREQ, 24'hFFFFFF);
          write_reg(CFG_AMP, 24'hFFFFFF);
        end
        3: begin
          write_reg(CFG_OCTAVES, 16); write_reg(CFG_FREQ, 24'($urandom));
          write_reg(CFG_AMP, 24'($urandom));
        end
        default: begin
          write_reg(CFG_OCTAVES, 24'($urandom_range(1, 3)));
          write_reg(CFG_FREQ, 24'($urandom)); write_reg(CFG_AMP, 24'($urandom));
        end
      endcase
      send_item(mk(OP_FBM2, 0, 0, $urandom, $urandom, 0));
      send_item(mk(OP_FBM3, 0, 0, $urandom, $urandom, $urandom));
      phase_items = (p < 4) ? 30 : (RANDOM_ITEMS - 120) / 2;
      idle_free = (p == 5);
      for (int n = 0; n < phase_items; n++) send_item(random_item());
      idle_free = 0;
      drain();
    end

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
